/* hdl/sat_pkg.sv */
// Package: types, sizes and codes shared by the sorted array table files.
`timescale 1ns / 1ps

package sat_pkg;

    // Table sizing
    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int AW          = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Fixed field widths of the request and response transfers
    localparam int KIND_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef logic [KIND_W-1:0]      kind_t;
    typedef logic [WORD_W-1:0]      word_t;
    typedef logic [STATUS_W-1:0]    status_t;
    typedef logic [COUNT_W-1:0]     count_t;
    typedef logic [VALUE_WIDTH-1:0] val_t;
    typedef logic [AW-1:0]          addr_t;
    typedef logic [CNT_W-1:0]       cnt_t;

    // Request kinds
    localparam kind_t KIND_INSERT   = 3'd0;
    localparam kind_t KIND_DELETE   = 3'd1;
    localparam kind_t KIND_CONTAINS = 3'd2;
    localparam kind_t KIND_CLEAR    = 3'd3;
    localparam kind_t KIND_RESET    = 3'd4;
    localparam kind_t KIND_NEXT     = 3'd5;

    // Response status codes
    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_FULL     = 2'd1;
    localparam status_t STATUS_NOTFOUND = 2'd2;
    localparam status_t STATUS_BOUNDS   = 2'd3;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHF_RD,
        ST_SHF_WR,
        ST_NXT_RD,
        ST_NXT_WAIT,
        ST_FINISH
    } state_t;

endpackage

/* hdl/sat_if.sv */
// Interfaces: request and response channels of the sorted array table.
`timescale 1ns / 1ps

interface sat_req_if;
    logic               valid;
    logic               ready;
    sat_pkg::kind_t     kind;
    sat_pkg::word_t     value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface sat_rsp_if;
    logic               valid;
    logic               ready;
    sat_pkg::status_t   status;
    logic               found;
    sat_pkg::word_t     entry_out;
    sat_pkg::count_t    count;
    logic               is_full;

    modport source (output valid, output status, output found, output entry_out,
                    output count, output is_full, input ready);
    modport sink   (input valid, input status, input found, input entry_out,
                    input count, input is_full, output ready);
endinterface

/* hdl/sat_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module sat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                  wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hdl/sorted_array_table.sv */
// Top level: sorted value table with insert, delete, lookup and an in-order read cursor.
`timescale 1ns / 1ps

// Holds up to CAPACITY values in ascending order in a single-port-write RAM
// and serves one request at a time on req, answering each with exactly one
// transfer on rsp. Every step of work is one RAM read followed by one compare
// and at most one RAM write, so the time per request follows the number of
// entries touched: insert moves each larger entry up one place, delete scans
// up to the match and shifts later entries down, contains scans up to the
// match, and next reads the entry at the cursor. A finished request waits
// in the finish state until the output register is free. req.ready is high
// only while the sequencer is idle; a finished response waits in its output
// register without blocking the next request. Stored entries have no reset;
// only entries below the count are ever used.
module sorted_array_table (
    input  logic      clk,
    input  logic      rst_n,
    sat_req_if.sink   req,
    sat_rsp_if.source rsp
);

    sat_pkg::state_t  state_reg,  state_next;
    sat_pkg::cnt_t    count_reg,  count_next;
    sat_pkg::cnt_t    pos_reg,    pos_next;
    sat_pkg::cnt_t    idx_reg,    idx_next;
    logic             rsp_valid_reg, rsp_valid_next;

    sat_pkg::kind_t   op_reg,     op_next;
    sat_pkg::val_t    val_reg,    val_next;
    sat_pkg::status_t status_reg, status_next;
    logic             found_reg,  found_next;
    sat_pkg::val_t    entry_reg,  entry_next;

    sat_pkg::status_t rsp_status_reg, rsp_status_next;
    logic             rsp_found_reg,  rsp_found_next;
    sat_pkg::word_t   rsp_entry_reg,  rsp_entry_next;
    sat_pkg::count_t  rsp_count_reg,  rsp_count_next;
    logic             rsp_full_reg,   rsp_full_next;

    logic             ram_we;
    sat_pkg::addr_t   ram_waddr;
    sat_pkg::val_t    ram_wdata;
    sat_pkg::addr_t   ram_raddr;
    sat_pkg::val_t    ram_rdata;

    logic             req_fire;
    logic             slot_free;
    logic             table_full;
    logic             rd_greater;
    logic             rd_equal;
    logic             idx_at_end;
    logic             pos_at_end;

    // Entry store
    sat_ram #(
        .WIDTH (sat_pkg::VALUE_WIDTH),
        .DEPTH (sat_pkg::CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshakes and shared compare unit
    assign req.ready  = (state_reg == sat_pkg::ST_IDLE);
    assign req_fire   = req.valid && (state_reg == sat_pkg::ST_IDLE);
    assign slot_free  = !rsp_valid_reg || rsp.ready;
    assign table_full = (count_reg >= sat_pkg::cnt_t'(sat_pkg::CAPACITY));
    assign rd_greater = (ram_rdata > val_reg);
    assign rd_equal   = (ram_rdata == val_reg);
    assign idx_at_end = (idx_reg >= count_reg);
    assign pos_at_end = (pos_reg >= count_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sat_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req.kind)
                        sat_pkg::KIND_INSERT:
                        begin
                            if (table_full)
                                state_next = sat_pkg::ST_FINISH;
                            else if (count_reg == '0)
                                state_next = sat_pkg::ST_INS_PUT;
                            else
                                state_next = sat_pkg::ST_INS_RD;
                        end
                        sat_pkg::KIND_DELETE, sat_pkg::KIND_CONTAINS:
                            state_next = sat_pkg::ST_SRCH_RD;
                        sat_pkg::KIND_NEXT:
                            state_next = pos_at_end ? sat_pkg::ST_FINISH : sat_pkg::ST_NXT_RD;
                        default:
                            state_next = sat_pkg::ST_FINISH;
                    endcase
                end
            end
            sat_pkg::ST_INS_RD:
                state_next = sat_pkg::ST_INS_CMP;
            sat_pkg::ST_INS_CMP:
            begin
                if (!rd_greater)
                    state_next = sat_pkg::ST_FINISH;
                else if (idx_reg == sat_pkg::cnt_t'(1))
                    state_next = sat_pkg::ST_INS_PUT;
                else
                    state_next = sat_pkg::ST_INS_RD;
            end
            sat_pkg::ST_INS_PUT:
                state_next = sat_pkg::ST_FINISH;
            sat_pkg::ST_SRCH_RD:
                state_next = idx_at_end ? sat_pkg::ST_FINISH : sat_pkg::ST_SRCH_CMP;
            sat_pkg::ST_SRCH_CMP:
            begin
                if (!rd_equal)
                    state_next = sat_pkg::ST_SRCH_RD;
                else if (op_reg == sat_pkg::KIND_CONTAINS)
                    state_next = sat_pkg::ST_FINISH;
                else
                    state_next = sat_pkg::ST_SHF_RD;
            end
            sat_pkg::ST_SHF_RD:
                state_next = idx_at_end ? sat_pkg::ST_FINISH : sat_pkg::ST_SHF_WR;
            sat_pkg::ST_SHF_WR:
                state_next = sat_pkg::ST_SHF_RD;
            sat_pkg::ST_NXT_RD:
                state_next = sat_pkg::ST_NXT_WAIT;
            sat_pkg::ST_NXT_WAIT:
                state_next = sat_pkg::ST_FINISH;
            sat_pkg::ST_FINISH:
            begin
                if (slot_free)
                    state_next = sat_pkg::ST_IDLE;
            end
            default:
                state_next = sat_pkg::ST_IDLE;
        endcase
    end

    // Datapath, RAM control and response loading
    always_comb
    begin
        count_next      = count_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        entry_next      = entry_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_found_next  = rsp_found_reg;
        rsp_entry_next  = rsp_entry_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_full_next   = rsp_full_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[sat_pkg::AW-1:0];
        ram_wdata       = val_reg;
        ram_raddr       = idx_reg[sat_pkg::AW-1:0];

        unique case (state_reg)
            sat_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    op_next     = req.kind;
                    val_next    = sat_pkg::val_t'(req.value);
                    status_next = sat_pkg::STATUS_OK;
                    found_next  = 1'b0;
                    entry_next  = '0;
                    idx_next    = '0;
                    unique case (req.kind)
                        sat_pkg::KIND_INSERT:
                        begin
                            idx_next = count_reg;
                            if (table_full)
                                status_next = sat_pkg::STATUS_FULL;
                        end
                        sat_pkg::KIND_CLEAR:
                            count_next = '0;
                        sat_pkg::KIND_RESET:
                            pos_next = '0;
                        sat_pkg::KIND_NEXT:
                        begin
                            if (pos_at_end)
                                status_next = sat_pkg::STATUS_BOUNDS;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // Walk down from the top, moving larger entries up one place
            sat_pkg::ST_INS_RD:
                ram_raddr = sat_pkg::addr_t'(idx_reg - sat_pkg::cnt_t'(1));
            sat_pkg::ST_INS_CMP:
            begin
                ram_we = 1'b1;
                if (rd_greater)
                begin
                    ram_wdata = ram_rdata;
                    idx_next  = idx_reg - sat_pkg::cnt_t'(1);
                end
                else
                begin
                    count_next = count_reg + sat_pkg::cnt_t'(1);
                end
            end
            sat_pkg::ST_INS_PUT:
            begin
                ram_we     = 1'b1;
                count_next = count_reg + sat_pkg::cnt_t'(1);
            end
            // Scan up for the first equal entry
            sat_pkg::ST_SRCH_RD:
            begin
                if (idx_at_end)
                    status_next = sat_pkg::STATUS_NOTFOUND;
            end
            sat_pkg::ST_SRCH_CMP:
            begin
                if (rd_equal && op_reg == sat_pkg::KIND_CONTAINS)
                    found_next = 1'b1;
                else
                    idx_next = idx_reg + sat_pkg::cnt_t'(1);
            end
            // Close the gap by moving later entries down one place
            sat_pkg::ST_SHF_RD:
            begin
                if (idx_at_end)
                    count_next = count_reg - sat_pkg::cnt_t'(1);
            end
            sat_pkg::ST_SHF_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sat_pkg::addr_t'(idx_reg - sat_pkg::cnt_t'(1));
                ram_wdata = ram_rdata;
                idx_next  = idx_reg + sat_pkg::cnt_t'(1);
            end
            // Cursor read
            sat_pkg::ST_NXT_RD:
                ram_raddr = pos_reg[sat_pkg::AW-1:0];
            sat_pkg::ST_NXT_WAIT:
            begin
                entry_next = ram_rdata;
                pos_next   = pos_reg + sat_pkg::cnt_t'(1);
            end
            sat_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_found_next  = found_reg;
                    rsp_entry_next  = sat_pkg::word_t'(entry_reg);
                    rsp_count_next  = sat_pkg::count_t'(count_reg);
                    rsp_full_next   = (count_reg == sat_pkg::cnt_t'(sat_pkg::CAPACITY));
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sat_pkg::ST_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        entry_reg      <= entry_next;
        rsp_status_reg <= rsp_status_next;
        rsp_found_reg  <= rsp_found_next;
        rsp_entry_reg  <= rsp_entry_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_full_reg   <= rsp_full_next;
    end

    // Response channel
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.found     = rsp_found_reg;
    assign rsp.entry_out = rsp_entry_reg;
    assign rsp.count     = rsp_count_reg;
    assign rsp.is_full   = rsp_full_reg;

endmodule
